// ===== rtl/core/rotary_encoder_decoder_defines.svh =====
// assertion macros for the rotary encoder decoder
// no dependencies; included by the files that assert
`ifndef ROTARY_ENCODER_DECODER_DEFINES_SVH
`define ROTARY_ENCODER_DECODER_DEFINES_SVH

// same-cycle implication, held off during reset
`define RE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define RE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rotenc_pkg.sv =====
// types, constants and helpers shared by the rotary encoder decoder
// no dependencies
package rotenc_pkg;

    localparam int POS_W       = 7;
    localparam int PAIR_W      = 2;
    localparam int STEP_W      = 4;
    localparam int TIME_W      = 32;
    localparam int PRESS_W     = 16;
    localparam int TABLE_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int LONG_MAX_W  = PRESS_W + 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_TURN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CW_NEXT_TABLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CCW_NEXT_TABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESS_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS  = 3'd4;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_BUTTON = 1'b1;

    localparam logic signed [STEP_W-1:0] STEP_LIMIT_POS  = 4'sd3;
    localparam logic signed [STEP_W-1:0] STEP_LIMIT_NEG  = -4'sd3;
    localparam logic [2:0]               LONG_MAX_FACTOR = 3'd5;

    typedef struct packed {
        logic [POS_W-1:0]   ticks_per_turn;
        logic [TABLE_W-1:0] cw_next_table;
        logic [TABLE_W-1:0] ccw_next_table;
        logic [PRESS_W-1:0] min_press_ms;
        logic [PRESS_W-1:0] long_press_ms;
    } t_cfg;

    typedef struct packed {
        logic [PAIR_W-1:0] last_pair;
        logic [STEP_W-1:0] step_count;
        logic [POS_W-1:0]  turn_position;
        logic [TIME_W-1:0] press_start;
        logic              short_pending;
        logic              long_pending;
    } t_state;

    typedef struct packed {
        logic              kind;
        logic              a_level;
        logic              b_level;
        logic              fell;
        logic              rose;
        logic [TIME_W-1:0] time_ms;
    } t_item;

    typedef struct packed {
        logic             rotate_valid;
        logic             clockwise;
        logic [POS_W-1:0] position;
        logic             short_press;
        logic             long_press;
    } t_result;

    localparam t_cfg CFG_RESET = '{
        ticks_per_turn: 7'd20,
        cw_next_table:  8'd141,
        ccw_next_table: 8'd114,
        min_press_ms:   16'd50,
        long_press_ms:  16'd1000
    };

    localparam t_state STATE_RESET = '{
        last_pair:     2'd3,
        step_count:    4'd0,
        turn_position: 7'd0,
        press_start:   32'd0,
        short_pending: 1'b0,
        long_pending:  1'b0
    };

    function automatic logic [PAIR_W-1:0] table_entry(
        input logic [TABLE_W-1:0] tbl,
        input logic [PAIR_W-1:0]  idx
    );
        return tbl[{idx, 1'b0} +: PAIR_W];
    endfunction

    function automatic logic [POS_W-1:0] pos_inc(
        input logic [POS_W-1:0] pos,
        input logic [POS_W-1:0] ticks
    );
        logic [POS_W-1:0] p;
        p = pos + 1'b1;
        return (p == ticks) ? '0 : p;
    endfunction

    function automatic logic [POS_W-1:0] pos_dec(
        input logic [POS_W-1:0] pos,
        input logic [POS_W-1:0] ticks
    );
        return (pos == '0) ? ticks - 1'b1 : pos - 1'b1;
    endfunction

endpackage

// ===== rtl/core/rotenc_in_if.sv =====
// input item channel of the rotary encoder decoder
// depends on rotenc_pkg
interface rotenc_in_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic                            a_level;
    logic                            b_level;
    logic                            fell;
    logic                            rose;
    logic [rotenc_pkg::TIME_W-1:0]   time_ms;

    modport source (output valid, kind, a_level, b_level, fell, rose, time_ms, input ready);
    modport sink   (input valid, kind, a_level, b_level, fell, rose, time_ms, output ready);
endinterface

// ===== rtl/core/rotenc_out_if.sv =====
// result channel of the rotary encoder decoder
// depends on rotenc_pkg
interface rotenc_out_if;
    logic                           valid;
    logic                           ready;
    logic                           rotate_valid;
    logic                           clockwise;
    logic [rotenc_pkg::POS_W-1:0]   position;
    logic                           short_press;
    logic                           long_press;

    modport source (output valid, rotate_valid, clockwise, position, short_press, long_press,
                    input ready);
    modport sink   (input valid, rotate_valid, clockwise, position, short_press, long_press,
                    output ready);
endinterface

// ===== rtl/core/rotenc_cfg_if.sv =====
// register write channel of the rotary encoder decoder
// depends on rotenc_pkg
interface rotenc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [rotenc_pkg::CFG_IDX_W-1:0]    reg_index;
    logic [rotenc_pkg::CFG_DATA_W-1:0]   wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/core/rotenc_step.sv =====
// next-state and result logic for one item: quadrature stepping and press timing
// depends on rotenc_pkg
module rotenc_step (
    input  rotenc_pkg::t_cfg    i_cfg,
    input  rotenc_pkg::t_state  i_state,
    input  rotenc_pkg::t_item   i_item,
    output rotenc_pkg::t_state  o_state,
    output rotenc_pkg::t_result o_result
);
    import rotenc_pkg::*;

    logic [PAIR_W-1:0]     pair;
    logic                  cw_hit;
    logic                  ccw_hit;
    logic [PAIR_W-1:0]     pair_cw;
    logic [STEP_W-1:0]     cnt_inc;
    logic [STEP_W-1:0]     cnt_cw;
    logic [STEP_W-1:0]     cnt_dec;
    logic [STEP_W-1:0]     cnt_ccw;
    logic [POS_W-1:0]      pos_cw;
    logic [POS_W-1:0]      pos_ccw;
    logic                  rot_cw;
    logic                  rot_ccw;
    logic [TIME_W-1:0]     start;
    logic [TIME_W-1:0]     held;
    logic [LONG_MAX_W-1:0] long_max;
    logic                  press_ignored;
    logic                  press_short;

    // encoder path
    assign pair    = {i_item.a_level, i_item.b_level};
    assign cw_hit  = table_entry(i_cfg.cw_next_table, i_state.last_pair) == pair;
    assign pair_cw = cw_hit ? pair : i_state.last_pair;
    assign cnt_inc = i_state.step_count + 1'b1;
    assign rot_cw  = cw_hit && ($signed(cnt_inc) > STEP_LIMIT_POS);
    assign cnt_cw  = rot_cw ? '0 : (cw_hit ? cnt_inc : i_state.step_count);
    assign pos_cw  = rot_cw ? pos_inc(i_state.turn_position, i_cfg.ticks_per_turn)
                            : i_state.turn_position;

    assign ccw_hit = table_entry(i_cfg.ccw_next_table, pair_cw) == pair;
    assign cnt_dec = cnt_cw - 1'b1;
    assign rot_ccw = ccw_hit && ($signed(cnt_dec) < STEP_LIMIT_NEG);
    assign cnt_ccw = rot_ccw ? '0 : (ccw_hit ? cnt_dec : cnt_cw);
    assign pos_ccw = rot_ccw ? pos_dec(pos_cw, i_cfg.ticks_per_turn) : pos_cw;

    // button path
    assign start         = i_item.fell ? i_item.time_ms : i_state.press_start;
    assign held          = i_item.time_ms - start;
    assign long_max      = LONG_MAX_W'(i_cfg.long_press_ms) * LONG_MAX_W'(LONG_MAX_FACTOR);
    assign press_ignored = (held < TIME_W'(i_cfg.min_press_ms))
                        || (held > TIME_W'(long_max));
    assign press_short   = held < TIME_W'(i_cfg.long_press_ms);

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        unique case (i_item.kind)
            KIND_BUTTON: begin
                o_state.press_start = start;
                if (i_item.rose && !press_ignored) begin
                    if (press_short) begin
                        o_state.short_pending = 1'b1;
                    end else begin
                        o_state.long_pending = 1'b1;
                    end
                end
                o_result.position = i_state.turn_position;
            end
            default: begin
                o_state.short_pending  = 1'b0;
                o_state.long_pending   = 1'b0;
                o_state.last_pair      = ccw_hit ? pair : pair_cw;
                o_state.step_count     = cnt_ccw;
                o_state.turn_position  = pos_ccw;
                o_result.rotate_valid  = rot_cw || rot_ccw;
                o_result.clockwise     = rot_cw && !rot_ccw;
                o_result.position      = pos_ccw;
                o_result.short_press   = i_state.short_pending;
                o_result.long_press    = i_state.long_pending;
            end
        endcase
    end

endmodule

// ===== rtl/core/rotary_encoder_decoder.sv =====
// rotary encoder decoder top level: channels, registers and the two-stage datapath
// depends on rotenc_pkg, the channel interfaces, rotenc_step and the defines header
//
// Usage:
//   i_in carries one item per transfer: an encoder sample (kind 0, a_level and
//   b_level) or a button edge (kind 1, fell, rose and time_ms in milliseconds).
//   o_out returns exactly one result per item, in order: rotate_valid,
//   clockwise, position, short_press and long_press.
//   i_cfg writes register reg_index with wdata; it is always ready. It is to be
//   written only while no item is in flight; the user must ensure this, the block
//   does not enforce it. Unknown indexes are dropped. A result passes through
//   the input register, then the result register, before it is offered.
//   Throughput: one item per cycle while o_out does not stall, set by the
//   single state update between the two registers.
//   If the receiver stalls, the result register holds its result and the
//   input register takes one more item; i_in.ready then drops until o_out
//   takes the waiting result.
//   Reset restores the register defaults, the pair to both lines high, zero
//   step count, position and press time, and empties both stages.
`include "rotary_encoder_decoder_defines.svh"

module rotary_encoder_decoder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rotenc_in_if.sink        i_in,
    rotenc_out_if.source     o_out,
    rotenc_cfg_if.sink       i_cfg
);
    import rotenc_pkg::*;

    logic    r_in_valid;
    logic    n_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_result;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_cfg    r_cfg;
    t_cfg    n_cfg;
    logic    in_xfer;
    logic    advance;
    logic    step_ok;
    logic    dir_ok;
    logic    sample_adv;
    logic    no_pending;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign n_in_valid  = in_xfer || (r_in_valid && !advance);
    assign n_out_valid = advance || (r_out_valid && !o_out.ready);

    rotenc_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                CFG_TICKS_PER_TURN: n_cfg.ticks_per_turn = i_cfg.wdata[POS_W-1:0];
                CFG_CW_NEXT_TABLE:  n_cfg.cw_next_table  = i_cfg.wdata[TABLE_W-1:0];
                CFG_CCW_NEXT_TABLE: n_cfg.ccw_next_table = i_cfg.wdata[TABLE_W-1:0];
                CFG_MIN_PRESS_MS:   n_cfg.min_press_ms   = i_cfg.wdata[PRESS_W-1:0];
                CFG_LONG_PRESS_MS:  n_cfg.long_press_ms  = i_cfg.wdata[PRESS_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
            r_cfg       <= CFG_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_cfg       <= n_cfg;
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.kind    <= i_in.kind;
            r_item.a_level <= i_in.a_level;
            r_item.b_level <= i_in.b_level;
            r_item.fell    <= i_in.fell;
            r_item.rose    <= i_in.rose;
            r_item.time_ms <= i_in.time_ms;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.rotate_valid = r_result.rotate_valid;
    assign o_out.clockwise    = r_result.clockwise;
    assign o_out.position     = r_result.position;
    assign o_out.short_press  = r_result.short_press;
    assign o_out.long_press   = r_result.long_press;

    assign step_ok    = ($signed(r_state.step_count) <= STEP_LIMIT_POS)
                     && ($signed(r_state.step_count) >= STEP_LIMIT_NEG);
    assign dir_ok     = !r_out_valid || r_result.rotate_valid || !r_result.clockwise;
    assign sample_adv = advance && (r_item.kind == KIND_SAMPLE);
    assign no_pending = !r_state.short_pending && !r_state.long_pending;

    `RE_ASSERT_NOW(a_step_range, i_clk, i_rst_n, 1'b1, step_ok, "step count left its range")
    `RE_ASSERT_NEXT(a_advance_fills, i_clk, i_rst_n, advance, r_out_valid, "result not loaded")
    `RE_ASSERT_NOW(a_dir_needs_rot, i_clk, i_rst_n, 1'b1, dir_ok, "direction without rotation")
    `RE_ASSERT_NEXT(a_sample_clears, i_clk, i_rst_n, sample_adv, no_pending, "press not cleared")

endmodule
